/* rtl/core/ppack_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppack_pkg
// Shared types, codes and reset values of the palette pixel packer.
// ----------------------------------------------------------------------------
package ppack_pkg;

    localparam int CHAN_BITS       = 8;
    localparam int MASK_W          = 16;
    localparam int PIX_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int PALETTE_ENTRIES = 256;
    localparam int OUT_WIDTH       = 16;

    localparam int LSB_W = $clog2(MASK_W);
    localparam int CNT_W = $clog2(MASK_W + 1);
    localparam int RSH_W = $clog2(CHAN_BITS + 1);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RED_MASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE = 2'd3;

    localparam logic [MASK_W-1:0] RED_MASK_RST   = 16'hF800;
    localparam logic [MASK_W-1:0] GREEN_MASK_RST = 16'h07E0;
    localparam logic [MASK_W-1:0] BLUE_MASK_RST  = 16'h001F;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic MODE_INDEXED = 1'b0;
    localparam logic MODE_DIRECT  = 1'b1;

    typedef struct packed {
        logic [CHAN_BITS-1:0] r;
        logic [CHAN_BITS-1:0] g;
        logic [CHAN_BITS-1:0] b;
    } rgb_t;

    // decoded placement of one channel
    typedef struct packed {
        logic [RSH_W-1:0] rsh;
        logic [LSB_W-1:0] lsb;
    } chan_cfg_t;

    typedef struct packed {
        logic valid;
        logic use_palette;
        logic zero;
    } s1_ctl_t;

endpackage

/* rtl/core/ppack_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppack_cfg
// Configuration registers and registered decode of the three channel masks.
// ----------------------------------------------------------------------------
module ppack_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ppack_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppack_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output ppack_pkg::chan_cfg_t               red_cfg,
    output ppack_pkg::chan_cfg_t               green_cfg,
    output ppack_pkg::chan_cfg_t               blue_cfg,
    output logic                               source_mode
);

    logic [ppack_pkg::MASK_W-1:0] red_mask_reg;
    logic [ppack_pkg::MASK_W-1:0] green_mask_reg;
    logic [ppack_pkg::MASK_W-1:0] blue_mask_reg;
    logic                         source_mode_reg;

    ppack_pkg::chan_cfg_t red_cfg_reg, green_cfg_reg, blue_cfg_reg;
    ppack_pkg::chan_cfg_t red_cfg_next, green_cfg_next, blue_cfg_next;

    function automatic ppack_pkg::chan_cfg_t decode_mask(
        input logic [ppack_pkg::MASK_W-1:0] mask
    );
        logic [ppack_pkg::CNT_W-1:0] cnt;
        logic [ppack_pkg::RSH_W-1:0] n;
        ppack_pkg::chan_cfg_t        d;
        cnt   = '0;
        d.lsb = '0;
        for (int i = 0; i < ppack_pkg::MASK_W; i++) begin
            cnt = cnt + ppack_pkg::CNT_W'(mask[i]);
        end
        // scan downward so the lowest set bit wins
        for (int i = ppack_pkg::MASK_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                d.lsb = ppack_pkg::LSB_W'(i);
            end
        end
        if (cnt > ppack_pkg::CNT_W'(ppack_pkg::CHAN_BITS)) begin
            n = ppack_pkg::RSH_W'(ppack_pkg::CHAN_BITS);
        end else begin
            n = ppack_pkg::RSH_W'(cnt);
        end
        // an empty mask shifts the whole channel out
        d.rsh = ppack_pkg::RSH_W'(ppack_pkg::CHAN_BITS) - n;
        return d;
    endfunction

    always_comb begin
        red_cfg_next   = decode_mask(red_mask_reg);
        green_cfg_next = decode_mask(green_mask_reg);
        blue_cfg_next  = decode_mask(blue_mask_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_mask_reg    <= ppack_pkg::RED_MASK_RST;
            green_mask_reg  <= ppack_pkg::GREEN_MASK_RST;
            blue_mask_reg   <= ppack_pkg::BLUE_MASK_RST;
            source_mode_reg <= ppack_pkg::MODE_INDEXED;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ppack_pkg::REG_RED_MASK:    red_mask_reg    <= cfg_wr_data;
                ppack_pkg::REG_GREEN_MASK:  green_mask_reg  <= cfg_wr_data;
                ppack_pkg::REG_BLUE_MASK:   blue_mask_reg   <= cfg_wr_data;
                ppack_pkg::REG_SOURCE_MODE: source_mode_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        red_cfg_reg   <= red_cfg_next;
        green_cfg_reg <= green_cfg_next;
        blue_cfg_reg  <= blue_cfg_next;
    end

    assign red_cfg     = red_cfg_reg;
    assign green_cfg   = green_cfg_reg;
    assign blue_cfg    = blue_cfg_reg;
    assign source_mode = source_mode_reg;

endmodule

/* rtl/core/ppack_palette.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppack_palette
// Palette memory and first pipeline stage: writes entries, reads the entry of
// an indexed pixel and registers the direct colour alongside.
// ----------------------------------------------------------------------------
module ppack_palette #(
    parameter int PALETTE_ENTRIES = ppack_pkg::PALETTE_ENTRIES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             accept,
    input  logic                             cmd,
    input  logic [ppack_pkg::CHAN_BITS-1:0]  color_index,
    input  ppack_pkg::rgb_t                  color_in,
    input  logic                             source_mode,
    output ppack_pkg::s1_ctl_t               s1_ctl,
    output ppack_pkg::rgb_t                  s1_direct,
    output ppack_pkg::rgb_t                  s1_entry
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int IW = ppack_pkg::CHAN_BITS + 1;

    ppack_pkg::rgb_t    mem [PALETTE_ENTRIES];
    ppack_pkg::rgb_t    entry_reg;
    ppack_pkg::rgb_t    direct_reg;
    ppack_pkg::s1_ctl_t ctl_reg;
    ppack_pkg::s1_ctl_t ctl_next;
    logic               in_range;
    logic [AW-1:0]      addr;

    assign in_range = {1'b0, color_index} < IW'(PALETTE_ENTRIES);
    assign addr     = AW'(color_index);

    always_comb begin
        ctl_next.valid       = accept && (cmd == ppack_pkg::CMD_CONVERT);
        ctl_next.use_palette = (source_mode == ppack_pkg::MODE_INDEXED);
        ctl_next.zero        = !in_range;
    end

    always_ff @(posedge aclk) begin
        if (accept && (cmd == ppack_pkg::CMD_WRITE) && in_range) begin
            mem[addr] <= color_in;
        end
        if (en && in_range) begin
            entry_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            direct_reg <= color_in;
        end
    end

    assign s1_ctl    = ctl_reg;
    assign s1_direct = direct_reg;
    assign s1_entry  = entry_reg;

endmodule

/* rtl/core/ppack_pack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppack_pack
// Colour select and channel trim stage, then placement, merge and output
// register stage.
// ----------------------------------------------------------------------------
module ppack_pack #(
    parameter int OUT_WIDTH = ppack_pkg::OUT_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  ppack_pkg::s1_ctl_t             s1_ctl,
    input  ppack_pkg::rgb_t                s1_direct,
    input  ppack_pkg::rgb_t                s1_entry,
    input  ppack_pkg::chan_cfg_t           red_cfg,
    input  ppack_pkg::chan_cfg_t           green_cfg,
    input  ppack_pkg::chan_cfg_t           blue_cfg,
    output logic                           s2_valid,
    output logic                           m_valid,
    output logic [ppack_pkg::PIX_W-1:0]    m_packed_pixel
);

    localparam int PLACE_W = ppack_pkg::CHAN_BITS + ppack_pkg::MASK_W - 1;
    localparam int TRIM_W  = (OUT_WIDTH < ppack_pkg::PIX_W) ? OUT_WIDTH : ppack_pkg::PIX_W;

    ppack_pkg::rgb_t             color;
    ppack_pkg::rgb_t             kept_next, kept_reg;
    logic                        s2_valid_reg;
    logic [PLACE_W-1:0]          placed;
    logic [ppack_pkg::PIX_W-1:0] pixel_next, pixel_reg;
    logic                        m_valid_reg;

    always_comb begin
        if (!s1_ctl.use_palette) begin
            color = s1_direct;
        end else if (s1_ctl.zero) begin
            color = '0;
        end else begin
            color = s1_entry;
        end
        kept_next.r = color.r >> red_cfg.rsh;
        kept_next.g = color.g >> green_cfg.rsh;
        kept_next.b = color.b >> blue_cfg.rsh;
    end

    always_comb begin
        placed = (PLACE_W'(kept_reg.r) << red_cfg.lsb)
               | (PLACE_W'(kept_reg.g) << green_cfg.lsb)
               | (PLACE_W'(kept_reg.b) << blue_cfg.lsb);
        pixel_next = ppack_pkg::PIX_W'(placed[TRIM_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_ctl.valid;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kept_reg  <= kept_next;
            pixel_reg <= pixel_next;
        end
    end

    assign s2_valid       = s2_valid_reg;
    assign m_valid        = m_valid_reg;
    assign m_packed_pixel = pixel_reg;

endmodule

/* rtl/core/palette_rgb_to_masked_pixel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_rgb_to_masked_pixel
// Palette or direct RGB source to mask-packed destination pixel.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and keeps that rate for as long as the
// result side takes its transactions. A convert transaction reaches
// m_packed_pixel through three register stages, in order: the registered
// palette read at the accepting edge, colour select and channel trim, and
// placement and merge into the output register. A palette write yields no
// result and occupies one pipeline slot. When the result waits, the whole
// pipeline holds and s_ready drops. Mask decode is registered, so a
// configuration write applies to transactions accepted from the clock edge
// after the write onward.
module palette_rgb_to_masked_pixel #(
    parameter int PALETTE_ENTRIES = ppack_pkg::PALETTE_ENTRIES,
    parameter int OUT_WIDTH       = ppack_pkg::OUT_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ppack_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppack_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [ppack_pkg::CHAN_BITS-1:0]  s_color_index,
    input  logic [ppack_pkg::CHAN_BITS-1:0]  s_red_in,
    input  logic [ppack_pkg::CHAN_BITS-1:0]  s_green_in,
    input  logic [ppack_pkg::CHAN_BITS-1:0]  s_blue_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ppack_pkg::PIX_W-1:0]      m_packed_pixel
);

    ppack_pkg::chan_cfg_t red_cfg, green_cfg, blue_cfg;
    ppack_pkg::s1_ctl_t   s1_ctl;
    ppack_pkg::rgb_t      s1_direct, s1_entry, color_in;
    logic                 source_mode;
    logic                 en;
    logic                 accept;
    logic                 s2_valid;

    // pipeline advances unless the output holds an untaken result
    assign en       = !m_valid || m_ready;
    assign s_ready  = en;
    assign accept   = s_valid && en;
    assign color_in = '{r: s_red_in, g: s_green_in, b: s_blue_in};

    ppack_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .red_cfg     (red_cfg),
        .green_cfg   (green_cfg),
        .blue_cfg    (blue_cfg),
        .source_mode (source_mode)
    );

    ppack_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .accept      (accept),
        .cmd         (s_cmd),
        .color_index (s_color_index),
        .color_in    (color_in),
        .source_mode (source_mode),
        .s1_ctl      (s1_ctl),
        .s1_direct   (s1_direct),
        .s1_entry    (s1_entry)
    );

    ppack_pack #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_pack (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .s1_ctl         (s1_ctl),
        .s1_direct      (s1_direct),
        .s1_entry       (s1_entry),
        .red_cfg        (red_cfg),
        .green_cfg      (green_cfg),
        .blue_cfg       (blue_cfg),
        .s2_valid       (s2_valid),
        .m_valid        (m_valid),
        .m_packed_pixel (m_packed_pixel)
    );

    // a palette write never enters the result path
    a_write_no_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == ppack_pkg::CMD_WRITE)) |=> !s1_ctl.valid
    ) else $error("palette write produced a pipeline slot");

    a_convert_enters: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == ppack_pkg::CMD_CONVERT)) |=> s1_ctl.valid
    ) else $error("convert transaction lost at first stage");

    a_stall_holds_s2: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(s2_valid) && $stable(s1_ctl.valid))
    ) else $error("pipeline moved during stall");

    a_s2_to_out: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (en && s2_valid) |=> m_valid
    ) else $error("result lost at output stage");

endmodule

/* test/tb_palette_rgb_to_masked_pixel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_rgb_to_masked_pixel
// Self-checking bench for the palette / direct RGB pixel packer.
// ----------------------------------------------------------------------------
// A queue of pending transactions feeds a clocked driver; every accepted
// transaction updates a local palette copy or predicts one packed pixel. A
// clocked monitor checks each result transaction against the oldest
// prediction. Directed items cover field extremes, empty and oversized
// masks and palette read-after-write; random segments then vary the mask
// and mode settings under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_palette_rgb_to_masked_pixel;

    typedef struct packed {
        logic                            cmd;
        logic [ppack_pkg::CHAN_BITS-1:0] idx;
        logic [ppack_pkg::CHAN_BITS-1:0] r;
        logic [ppack_pkg::CHAN_BITS-1:0] g;
        logic [ppack_pkg::CHAN_BITS-1:0] b;
    } px_item_t;

    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int SEGMENT_ITEMS  = 137;

    logic                             aclk;
    logic                             aresetn       = 1'b0;
    logic                             cfg_wr_en     = 1'b0;
    logic [ppack_pkg::CFG_IDX_W-1:0]  cfg_index     = ppack_pkg::REG_RED_MASK;
    logic [ppack_pkg::CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                             s_valid       = 1'b0;
    logic                             s_ready;
    logic                             s_cmd         = ppack_pkg::CMD_WRITE;
    logic [ppack_pkg::CHAN_BITS-1:0]  s_color_index = '0;
    logic [ppack_pkg::CHAN_BITS-1:0]  s_red_in      = '0;
    logic [ppack_pkg::CHAN_BITS-1:0]  s_green_in    = '0;
    logic [ppack_pkg::CHAN_BITS-1:0]  s_blue_in     = '0;
    logic                             m_valid;
    logic                             m_ready       = 1'b0;
    logic [ppack_pkg::PIX_W-1:0]      m_packed_pixel;

    // shadow of the block's configuration and palette
    logic [ppack_pkg::MASK_W-1:0] red_mask_q   = ppack_pkg::RED_MASK_RST;
    logic [ppack_pkg::MASK_W-1:0] green_mask_q = ppack_pkg::GREEN_MASK_RST;
    logic [ppack_pkg::MASK_W-1:0] blue_mask_q  = ppack_pkg::BLUE_MASK_RST;
    logic                         src_mode_q   = ppack_pkg::MODE_INDEXED;
    ppack_pkg::rgb_t              palette_copy [ppack_pkg::PALETTE_ENTRIES];

    px_item_t                    pending_px [$];
    logic [ppack_pkg::PIX_W-1:0] expected_pixels [$];

    // generator side bookkeeping of loaded palette entries
    bit idx_loaded [ppack_pkg::PALETTE_ENTRIES];
    int loaded_list [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int mismatches    = 0;

    palette_rgb_to_masked_pixel dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_color_index  (s_color_index),
        .s_red_in       (s_red_in),
        .s_green_in     (s_green_in),
        .s_blue_in      (s_blue_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packed_pixel (m_packed_pixel)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("palette_rgb_to_masked_pixel verification failed");
        $finish;
    end

    // top bits of one channel, moved to the lowest set bit of its mask
    function automatic logic [31:0] align_channel(
        logic [ppack_pkg::CHAN_BITS-1:0] chan,
        logic [ppack_pkg::MASK_W-1:0]    mask
    );
        int ones;
        int low;
        ones = 0;
        low  = -1;
        for (int i = 0; i < ppack_pkg::MASK_W; i++) begin
            if (mask[i]) begin
                ones++;
                if (low < 0) low = i;
            end
        end
        if (ones == 0) return '0;
        if (ones > ppack_pkg::CHAN_BITS) ones = ppack_pkg::CHAN_BITS;
        return (32'(chan) >> (ppack_pkg::CHAN_BITS - ones)) << low;
    endfunction

    function automatic logic [ppack_pkg::PIX_W-1:0] pack_pixel(ppack_pkg::rgb_t c);
        logic [31:0] merged;
        merged = align_channel(c.r, red_mask_q) | align_channel(c.g, green_mask_q) |
                 align_channel(c.b, blue_mask_q);
        return merged[ppack_pkg::PIX_W-1:0];
    endfunction

    function void account_item(px_item_t it);
        ppack_pkg::rgb_t c;
        if (it.cmd == ppack_pkg::CMD_WRITE) begin
            palette_copy[it.idx] = {it.r, it.g, it.b};
        end else begin
            c = (src_mode_q == ppack_pkg::MODE_DIRECT)
                ? ppack_pkg::rgb_t'({it.r, it.g, it.b})
                : palette_copy[it.idx];
            expected_pixels.push_back(pack_pixel(c));
        end
    endfunction

    // driver
    always @(posedge aclk) begin : drive_px
        px_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                account_item({s_cmd, s_color_index, s_red_in, s_green_in, s_blue_in});
            end
            if (!s_valid || s_ready) begin
                if (pending_px.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_px.pop_front();
                    s_cmd         <= nxt.cmd;
                    s_color_index <= nxt.idx;
                    s_red_in      <= nxt.r;
                    s_green_in    <= nxt.g;
                    s_blue_in     <= nxt.b;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : check_px
        logic [ppack_pkg::PIX_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("packed_pixel: no transaction expected, actual %h", m_packed_pixel);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_packed_pixel !== want) begin
                    $error("packed_pixel: expected %h, actual %h", want, m_packed_pixel);
                    mismatches++;
                end
            end
        end
    end

    task automatic push_px(logic cmd, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
        pending_px.push_back({cmd, idx, r, g, b});
        if (cmd == ppack_pkg::CMD_WRITE && !idx_loaded[idx]) begin
            idx_loaded[idx] = 1'b1;
            loaded_list.push_back(int'(idx));
        end
    endtask

    // wait until every queued transaction is through, then let the pipe empty
    task automatic drain();
        @(negedge aclk);
        while (pending_px.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(logic [15:0] rm, logic [15:0] gm, logic [15:0] bm,
                                 logic mode);
        drain();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= ppack_pkg::REG_RED_MASK;
        cfg_wr_data <= rm;
        @(posedge aclk);
        cfg_index   <= ppack_pkg::REG_GREEN_MASK;
        cfg_wr_data <= gm;
        @(posedge aclk);
        cfg_index   <= ppack_pkg::REG_BLUE_MASK;
        cfg_wr_data <= bm;
        @(posedge aclk);
        cfg_index   <= ppack_pkg::REG_SOURCE_MODE;
        cfg_wr_data <= {{(ppack_pkg::CFG_DATA_W-1){1'b0}}, mode};
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        red_mask_q   = rm;
        green_mask_q = gm;
        blue_mask_q  = bm;
        src_mode_q   = mode;
        // mask decode is registered
        repeat (3) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_mask();
        int lo;
        int len;
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 16'(32'h1 << $urandom_range(15));
            3: begin
                lo  = $urandom_range(15);
                len = $urandom_range(1, 16 - lo);
                return 16'(((32'h1 << len) - 1) << lo);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (src_mode_q == ppack_pkg::MODE_INDEXED) begin
                // mostly lookups of loaded entries, some fresh loads
                if (pick < 30 || loaded_list.size() == 0)
                    push_px(ppack_pkg::CMD_WRITE, rnd8(), rnd8(), rnd8(), rnd8());
                else
                    push_px(ppack_pkg::CMD_CONVERT,
                            8'(loaded_list[$urandom_range(loaded_list.size() - 1)]),
                            rnd8(), rnd8(), rnd8());
            end else begin
                push_px(pick < 20 ? ppack_pkg::CMD_WRITE : ppack_pkg::CMD_CONVERT,
                        rnd8(), rnd8(), rnd8(), rnd8());
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset setting: 565 masks, indexed source
        push_px(ppack_pkg::CMD_WRITE,   8'h00, 8'hFF, 8'hFF, 8'hFF);
        push_px(ppack_pkg::CMD_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00);
        push_px(ppack_pkg::CMD_WRITE,   8'hFF, 8'h00, 8'h00, 8'h00);
        push_px(ppack_pkg::CMD_CONVERT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_px(ppack_pkg::CMD_WRITE,   8'hA5, 8'h80, 8'h7F, 8'h01);
        push_px(ppack_pkg::CMD_CONVERT, 8'hA5, 8'h00, 8'h00, 8'h00);
        // overwrite followed directly by a lookup of the same entry
        push_px(ppack_pkg::CMD_WRITE,   8'h00, 8'h12, 8'h34, 8'h56);
        push_px(ppack_pkg::CMD_CONVERT, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        push_px(ppack_pkg::CMD_WRITE,   8'h5A, 8'h01, 8'h80, 8'hFE);
        push_px(ppack_pkg::CMD_CONVERT, 8'h5A, 8'h00, 8'h00, 8'h00);

        // empty red mask, green saturating at eight bits, split blue mask
        apply_setting(16'h0000, 16'hFFFF, 16'h8001, ppack_pkg::MODE_DIRECT);
        push_px(ppack_pkg::CMD_CONVERT, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        push_px(ppack_pkg::CMD_CONVERT, 8'hFF, 8'h00, 8'h00, 8'h00);
        push_px(ppack_pkg::CMD_CONVERT, 8'h3C, 8'hAA, 8'h55, 8'hC3);
        // palette load in direct mode gives no result
        push_px(ppack_pkg::CMD_WRITE,   8'h33, 8'h9E, 8'h21, 8'h7C);

        apply_setting(16'hFFFF, 16'h0001, 16'h0000, ppack_pkg::MODE_INDEXED);
        push_px(ppack_pkg::CMD_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00);
        push_px(ppack_pkg::CMD_CONVERT, 8'hFF, 8'h00, 8'h00, 8'h00);
        push_px(ppack_pkg::CMD_CONVERT, 8'h33, 8'h00, 8'h00, 8'h00);

        apply_setting(16'h8000, 16'h4000, 16'h3FFF, ppack_pkg::MODE_DIRECT);
        push_px(ppack_pkg::CMD_CONVERT, 8'h00, 8'hFF, 8'h80, 8'h7F);
        push_px(ppack_pkg::CMD_CONVERT, 8'hFF, 8'h01, 8'h02, 8'h04);

        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < 4; seg++) begin
                apply_setting(pick_mask(), pick_mask(), pick_mask(),
                              seg[0] ? ppack_pkg::MODE_DIRECT : ppack_pkg::MODE_INDEXED);
                case (phase)
                    0: begin
                        send_idle_pct = 24;
                        recv_idle_pct = 81;
                    end
                    1: begin
                        send_idle_pct = 81;
                        recv_idle_pct = 24;
                    end
                    default: begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                queue_random(SEGMENT_ITEMS);
                // result side holds off while transactions keep coming
                if (seg == 0) hold_req++;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("palette_rgb_to_masked_pixel verification clean");
        else
            $display("palette_rgb_to_masked_pixel verification failed");
        $finish;
    end

endmodule
